// ----- design/bfi_pkg.sv -----
// Shared types and constants for the Brainfuck interpreter core.
`default_nettype none
package bfi_pkg;

	localparam int TAPE_CELLS = 32768;
	localparam int CODE_DEPTH = 1024;
	localparam int LOOP_DEPTH = 64;

	localparam int TAPE_AW = $clog2(TAPE_CELLS);
	localparam int CODE_AW = $clog2(CODE_DEPTH);
	localparam int PC_W    = CODE_AW + 1;
	localparam int STK_AW  = $clog2(LOOP_DEPTH);
	localparam int STK_CW  = STK_AW + 1;
	localparam int SKIP_W  = 7;

	localparam logic [SKIP_W-1:0] SKIP_MAX = 7'd127;

	// Result status codes
	localparam logic [2:0] ST_EXEC      = 3'd0;
	localparam logic [2:0] ST_OUT       = 3'd1;
	localparam logic [2:0] ST_NEED      = 3'd2;
	localparam logic [2:0] ST_HALT      = 3'd3;
	localparam logic [2:0] ST_OVER      = 3'd4;
	localparam logic [2:0] ST_UNMATCHED = 3'd5;

	// Instruction characters
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	typedef struct packed {
		logic       mode;
		logic [7:0] code_char;
		logic       code_last;
		logic [7:0] input_byte;
		logic       input_valid;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_byte;
		logic [10:0] program_counter;
		logic [14:0] tape_position;
	} result_t;

	typedef struct packed {
		logic               rd_en;
		logic [TAPE_AW-1:0] rd_addr;
		logic               wr_en;
		logic [TAPE_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
	} tape_req_t;

endpackage
`default_nettype wire

// ----- design/bfi_ram.sv -----
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none
module bfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- design/bfi_tape.sv -----
// Tape memory with the post-reset clearing sweep.
`default_nettype none
module bfi_tape import bfi_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tape_req_t req,
	output logic [7:0]     rd_data,
	output logic           busy
);

	logic               clr_busy_q;
	logic [TAPE_AW-1:0] clr_addr_q;
	logic               wr_en;
	logic [TAPE_AW-1:0] wr_addr;
	logic [7:0]         wr_data;

	// Sweep zeros through every cell after reset, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == TAPE_AW'(TAPE_CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign wr_en   = clr_busy_q | req.wr_en;
	assign wr_addr = clr_busy_q ? clr_addr_q : req.wr_addr;
	assign wr_data = clr_busy_q ? 8'h00 : req.wr_data;
	assign busy    = clr_busy_q;

	bfi_ram #(
		.WIDTH(8),
		.DEPTH(TAPE_CELLS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (req.rd_en),
		.rd_addr(req.rd_addr),
		.rd_data(rd_data)
	);

endmodule
`default_nettype wire

// ----- design/brainfuck_interpreter_core_top.sv -----
// Top level of the Brainfuck interpreter core: sequencer, program store, loop stack and tape.
//
// Usage:
//  - Input channel (item_valid / item_stall / item): mode 0 beats append one program
//    character; code_last closes the program and rewinds pc, loop stack, skip and
//    stop state (tape and its pointer are kept). Mode 1 beats execute one step.
//  - Output channel (result_valid / result_stall / result): one beat per step
//    beat, none per load beat.
//  - Load beats complete in S_IDLE. Step beats first read the program character,
//    tape cell and stack top from their memories, then decode and write back in
//    S_EXEC. '>' and '<' pass through S_MOVE as well, since the cell under the moved
//    pointer is read again from the single tape read port.
//  - The output register loads at the edge that ends the step: the commit in
//    S_EXEC, or the exit from S_MOVE for '>' and '<'. A waiting result does
//    not block the next accept; a step finishing while the output register is
//    still stalled holds until the register frees.
//  - After reset the tape is cleared by a sweep over all TAPE_CELLS cells (32768),
//    during which item_stall stays high.
`default_nettype none
module brainfuck_interpreter_core_top import bfi_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MOVE = 2'd2;

	logic [1:0]         state_q;
	logic [PC_W-1:0]    pc_q;
	logic [PC_W-1:0]    len_q;
	logic               closed_q;
	logic [TAPE_AW-1:0] tp_q;
	logic [STK_CW-1:0]  cnt_q;
	logic [SKIP_W-1:0]  skip_q;
	logic               stopped_q;
	item_t              item_q;
	logic               result_valid_q;
	result_t            result_q;

	logic               acc;
	logic               acc_load;
	logic               acc_step;
	logic               out_free;
	logic               commit;
	logic               tape_busy;
	tape_req_t          tape_req;
	logic [7:0]         tape_rd;
	logic [7:0]         ch;
	logic [CODE_AW-1:0] stack_rd;
	logic               code_we;
	logic [CODE_AW-1:0] code_waddr;

	// next-step values
	logic [PC_W-1:0]    pc_nx;
	logic [TAPE_AW-1:0] tp_nx;
	logic [STK_CW-1:0]  cnt_nx;
	logic [SKIP_W-1:0]  skip_nx;
	logic               stop_nx;
	logic [2:0]         status;
	logic [7:0]         cell_nx;
	logic               tape_we;
	logic               stk_we;
	logic               move;

	assign item_stall = tape_busy | (state_q != S_IDLE);
	assign acc        = item_valid & ~item_stall;
	assign acc_load   = acc & ~item.mode;
	assign acc_step   = acc & item.mode;
	assign out_free   = ~result_valid_q | ~result_stall;
	// Moves never write a result here, so they need not wait for the output register
	assign commit     = (state_q == S_EXEC) & (move | out_free);

	// Program store: a closed program restarts at position 0; drop characters past the end
	assign code_waddr = closed_q ? '0 : len_q[CODE_AW-1:0];
	assign code_we    = acc_load & (closed_q | (len_q < PC_W'(CODE_DEPTH)));

	bfi_ram #(
		.WIDTH(8),
		.DEPTH(CODE_DEPTH)
	) u_code (
		.clk    (clk),
		.wr_en  (code_we),
		.wr_addr(code_waddr),
		.wr_data(item.code_char),
		.rd_en  (acc_step),
		.rd_addr(pc_q[CODE_AW-1:0]),
		.rd_data(ch)
	);

	// Loop stack: read the top at accept, push during the execute cycle
	bfi_ram #(
		.WIDTH(CODE_AW),
		.DEPTH(LOOP_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (commit & stk_we),
		.wr_addr(cnt_q[STK_AW-1:0]),
		.wr_data(pc_q[CODE_AW-1:0]),
		.rd_en  (acc_step),
		.rd_addr(STK_AW'(cnt_q - 1'b1)),
		.rd_data(stack_rd)
	);

	// Tape: read the current cell at accept, or the new cell after a pointer move
	always_comb begin
		tape_req.rd_en   = acc_step | (commit & move);
		tape_req.rd_addr = (state_q == S_EXEC) ? tp_nx : tp_q;
		tape_req.wr_en   = commit & tape_we;
		tape_req.wr_addr = tp_q;
		tape_req.wr_data = cell_nx;
	end

	bfi_tape u_tape (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tape_req),
		.rd_data(tape_rd),
		.busy   (tape_busy)
	);

	// Decode one step from the fetched character, cell and stack top
	always_comb begin
		pc_nx   = pc_q;
		tp_nx   = tp_q;
		cnt_nx  = cnt_q;
		skip_nx = skip_q;
		stop_nx = stopped_q;
		status  = ST_EXEC;
		cell_nx = tape_rd;
		tape_we = 1'b0;
		stk_we  = 1'b0;
		move    = 1'b0;
		if (stopped_q) begin
			status = ST_HALT;
		end else if (pc_q >= len_q) begin
			// Program ran out; a pending skip means the bracket never closed
			if (skip_q != '0) begin
				skip_nx = '0;
				stop_nx = 1'b1;
				status  = ST_UNMATCHED;
			end else begin
				status = ST_HALT;
			end
		end else if (skip_q != '0) begin
			// Forward skip: count nesting, one character per step
			if (ch == CH_OPEN) begin
				if (skip_q >= SKIP_MAX) begin
					stop_nx = 1'b1;
					status  = ST_OVER;
				end else begin
					skip_nx = skip_q + 1'b1;
					pc_nx   = pc_q + 1'b1;
				end
			end else begin
				if (ch == CH_CLOSE) begin
					skip_nx = skip_q - 1'b1;
				end
				pc_nx = pc_q + 1'b1;
			end
		end else begin
			case (ch)
				CH_RIGHT: begin
					tp_nx = (tp_q == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : tp_q + 1'b1;
					move  = 1'b1;
					pc_nx = pc_q + 1'b1;
				end
				CH_LEFT: begin
					tp_nx = (tp_q == '0) ? TAPE_AW'(TAPE_CELLS - 1) : tp_q - 1'b1;
					move  = 1'b1;
					pc_nx = pc_q + 1'b1;
				end
				CH_INC: begin
					cell_nx = tape_rd + 1'b1;
					tape_we = 1'b1;
					pc_nx   = pc_q + 1'b1;
				end
				CH_DEC: begin
					cell_nx = tape_rd - 1'b1;
					tape_we = 1'b1;
					pc_nx   = pc_q + 1'b1;
				end
				CH_OUT: begin
					status = ST_OUT;
					pc_nx  = pc_q + 1'b1;
				end
				CH_IN: begin
					if (!item_q.input_valid) begin
						status = ST_NEED;
					end else begin
						cell_nx = item_q.input_byte;
						tape_we = 1'b1;
						pc_nx   = pc_q + 1'b1;
					end
				end
				CH_OPEN: begin
					if (tape_rd != 8'h00) begin
						if (cnt_q >= STK_CW'(LOOP_DEPTH)) begin
							stop_nx = 1'b1;
							status  = ST_OVER;
						end else begin
							stk_we = 1'b1;
							cnt_nx = cnt_q + 1'b1;
							pc_nx  = pc_q + 1'b1;
						end
					end else begin
						skip_nx = SKIP_W'(1);
						pc_nx   = pc_q + 1'b1;
					end
				end
				CH_CLOSE: begin
					if (cnt_q == '0) begin
						stop_nx = 1'b1;
						status  = ST_UNMATCHED;
					end else begin
						// Pop and jump back so the '[' tests the cell again
						cnt_nx = cnt_q - 1'b1;
						pc_nx  = PC_W'(stack_rd);
					end
				end
				default: begin
					pc_nx = pc_q + 1'b1;
				end
			endcase
		end
	end

	// Sequencer and machine registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			len_q     <= '0;
			closed_q  <= 1'b0;
			tp_q      <= '0;
			cnt_q     <= '0;
			skip_q    <= '0;
			stopped_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc_load) begin
						if (closed_q) begin
							len_q <= PC_W'(1);
						end else if (len_q < PC_W'(CODE_DEPTH)) begin
							len_q <= len_q + 1'b1;
						end
						closed_q <= item.code_last | (closed_q & 1'b0);
						if (item.code_last) begin
							pc_q      <= '0;
							cnt_q     <= '0;
							skip_q    <= '0;
							stopped_q <= 1'b0;
						end
					end else if (acc_step) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						pc_q      <= pc_nx;
						tp_q      <= tp_nx;
						cnt_q     <= cnt_nx;
						skip_q    <= skip_nx;
						stopped_q <= stop_nx;
						state_q   <= move ? S_MOVE : S_IDLE;
					end
				end
				S_MOVE: begin
					// Hold until the output register frees
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the step beat for the execute cycle
	always_ff @(posedge clk) begin
		if (acc_step) begin
			item_q <= item;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((commit & ~move) | ((state_q == S_MOVE) & out_free)) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit & ~move) begin
			result_q.status          <= status;
			result_q.out_byte        <= cell_nx;
			result_q.program_counter <= 11'(pc_nx);
			result_q.tape_position   <= 15'(tp_nx);
		end else if ((state_q == S_MOVE) & out_free) begin
			result_q.status          <= ST_EXEC;
			result_q.out_byte        <= tape_rd;
			result_q.program_counter <= 11'(pc_q);
			result_q.tape_position   <= 15'(tp_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ----- tb/tb_brainfuck_interpreter_core_top.sv -----
// Self-checking testbench for the Brainfuck interpreter core top level.
`timescale 1ns / 1ps
module tb_brainfuck_interpreter_core_top;
	import bfi_pkg::*;

	localparam int WATCHDOG_LIMIT = 100000; // covers the tape sweep after reset several times
	localparam int HOLD_CYCLES    = 400;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_BEATS    = 15;
	localparam int DRAIN_CYCLES   = 20;

	// Machine tracker: mirrors program store, tape and loop stack, and
	// keeps the step results still owed by the block.
	class bf_machine_tracker;
		bit [7:0]          code_mem[CODE_DEPTH];
		bit [PC_W-1:0]     code_len;
		bit [7:0]          tape[TAPE_CELLS];
		bit [TAPE_AW-1:0]  head;
		bit [PC_W-1:0]     pc;
		bit [CODE_AW-1:0]  loop_stk[LOOP_DEPTH];
		bit [STK_CW-1:0]   depth;
		bit [SKIP_W-1:0]   skip;
		bit                stopped;
		bit                closed;
		result_t           pending_results[$];
		int                loads;
		int                steps;
		int                checked;
		int                mismatches;
		int                status_seen[6];

		function void load_char(item_t b);
			if (closed) begin
				code_len = '0;
				closed = 1'b0;
			end
			if (code_len < CODE_DEPTH) begin
				code_mem[code_len[CODE_AW-1:0]] = b.code_char;
				code_len++;
			end
			if (b.code_last) begin
				closed = 1'b1;
				pc = '0;
				depth = '0;
				skip = '0;
				stopped = 1'b0;
			end
		endfunction

		function result_t exec_step(item_t b);
			logic [7:0] ch;
			logic [2:0] st;
			result_t    r;
			st = ST_EXEC;
			if (stopped) begin
				st = ST_HALT;
			end else if (pc >= code_len) begin
				if (skip != 0) begin
					skip = '0;
					stopped = 1'b1;
					st = ST_UNMATCHED;
				end else begin
					st = ST_HALT;
				end
			end else begin
				ch = code_mem[pc[CODE_AW-1:0]];
				if (skip != 0) begin
					if (ch == CH_OPEN && skip >= SKIP_MAX) begin
						stopped = 1'b1;
						st = ST_OVER;
					end else begin
						if (ch == CH_OPEN)
							skip++;
						else if (ch == CH_CLOSE)
							skip--;
						pc++;
					end
				end else begin
					case (ch)
						CH_RIGHT: begin
							head++;
							pc++;
						end
						CH_LEFT: begin
							head--;
							pc++;
						end
						CH_INC: begin
							tape[head] = tape[head] + 8'd1;
							pc++;
						end
						CH_DEC: begin
							tape[head] = tape[head] - 8'd1;
							pc++;
						end
						CH_OUT: begin
							pc++;
							st = ST_OUT;
						end
						CH_IN: begin
							if (!b.input_valid) begin
								st = ST_NEED;
							end else begin
								tape[head] = b.input_byte;
								pc++;
							end
						end
						CH_OPEN: begin
							if (tape[head] == 8'd0) begin
								skip = 7'd1;
								pc++;
							end else if (depth >= LOOP_DEPTH) begin
								stopped = 1'b1;
								st = ST_OVER;
							end else begin
								loop_stk[depth[STK_AW-1:0]] = pc[CODE_AW-1:0];
								depth++;
								pc++;
							end
						end
						CH_CLOSE: begin
							if (depth == 0) begin
								stopped = 1'b1;
								st = ST_UNMATCHED;
							end else begin
								depth--;
								pc = {1'b0, loop_stk[depth[STK_AW-1:0]]};
							end
						end
						default: pc++;
					endcase
				end
			end
			r.status = st;
			r.out_byte = tape[head];
			r.program_counter = pc;
			r.tape_position = head;
			return r;
		endfunction

		function void note_beat(item_t b);
			if (!b.mode) begin
				load_char(b);
				loads++;
			end else begin
				pending_results.push_back(exec_step(b));
				steps++;
			end
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: unexpected result beat %p", got);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (want.status < 6)
				status_seen[want.status]++;
			if (got.status !== want.status || got.out_byte !== want.out_byte ||
			    got.program_counter !== want.program_counter ||
			    got.tape_position !== want.tape_position) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: step %0d expected %p got %p", checked, want, got);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	bf_machine_tracker tracker = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int idle_cycles = 0;
	logic [7:0] prog[$];

	brainfuck_interpreter_core_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Receiver: check every accepted result beat, then pick the next stall.
	// A hold request starts a long stall that this process counts out itself.
	int hold_left = 0;
	int holds_done = 0;
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_beat(result);
		if (holds_done != hold_requests) begin
			holds_done = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one beat, with random idle cycles first; hold the payload until accepted.
	task automatic send_item(input item_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		do
			@(posedge clk);
		while (item_stall);
		tracker.note_beat(b);
	endtask

	// Load the characters in prog; close the program on the last one if asked.
	// Noise loads may also carry a stray close mark in the middle.
	task automatic load_prog(input bit close, input bit stray_last);
		item_t b;
		for (int i = 0; i < prog.size(); i++) begin
			b.mode = 1'b0;
			b.code_char = prog[i];
			b.code_last = (close && i == prog.size() - 1) ||
			              (stray_last && $urandom_range(0, 9) == 0);
			b.input_byte = 8'($urandom_range(0, 255));
			b.input_valid = 1'($urandom_range(0, 1));
			send_item(b);
		end
	endtask

	// Issue step beats; a negative fixed_byte means a random input byte.
	task automatic run_steps(input int n, input int valid_pct, input int fixed_byte);
		item_t b;
		for (int i = 0; i < n; i++) begin
			b.mode = 1'b1;
			b.code_char = 8'($urandom_range(0, 255));
			b.code_last = 1'($urandom_range(0, 1));
			b.input_valid = ($urandom_range(0, 99) < valid_pct);
			b.input_byte = (fixed_byte < 0) ? 8'($urandom_range(0, 255)) : 8'(fixed_byte);
			send_item(b);
		end
	endtask

	// Drop the valid and wait until every owed result has come back.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 8))
			0, 1, 2: return CH_INC;
			3:       return CH_DEC;
			4:       return CH_RIGHT;
			5:       return CH_LEFT;
			6:       return CH_OUT;
			7:       return CH_IN;
			default: return CH_DEC;
		endcase
	endfunction

	function automatic logic [7:0] comment_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CH_OPEN || c == CH_CLOSE)
			c = 8'h20;
		return c;
	endfunction

	// Build a program with balanced brackets, nested at most six deep.
	function automatic void build_balanced(input int len);
		int open_cnt;
		int r;
		open_cnt = 0;
		prog.delete();
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12 && open_cnt < 6) begin
				prog.push_back(CH_OPEN);
				open_cnt++;
			end else if (r < 24 && open_cnt > 0) begin
				prog.push_back(CH_CLOSE);
				open_cnt--;
			end else if (r < 28) begin
				prog.push_back(comment_char());
			end else begin
				prog.push_back(pick_op());
			end
		end
		while (open_cnt > 0) begin
			prog.push_back(CH_CLOSE);
			open_cnt--;
		end
	endfunction

	// Build n copies of one character after a leading input instruction.
	function automatic void build_run(input logic [7:0] ch, input int n);
		prog.delete();
		prog.push_back(CH_IN);
		for (int i = 0; i < n; i++)
			prog.push_back(ch);
	endfunction

	task automatic random_program();
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		len = $urandom_range(4, 24);
		if (kind <= 6) begin
			// well-formed program, mostly fed with input
			build_balanced(len);
			load_prog(1'b1, 1'b0);
			run_steps($urandom_range(len, 3 * len + 10), 75, -1);
		end else if (kind == 7) begin
			// raw bytes, with stray close marks
			prog.delete();
			for (int i = 0; i < $urandom_range(1, 10); i++)
				prog.push_back(8'($urandom_range(0, 255)));
			load_prog(1'b1, 1'b1);
			run_steps($urandom_range(1, 12), 50, -1);
		end else if (kind == 8) begin
			// broken brackets: a stray close or an open that never closes
			build_balanced(len);
			if ($urandom_range(0, 1))
				prog.insert($urandom_range(0, prog.size()), CH_CLOSE);
			else
				prog.push_back(CH_OPEN);
			load_prog(1'b1, 1'b0);
			run_steps($urandom_range(len, 2 * len + 10), 75, -1);
		end else begin
			// open-ended load: start anew after a closed program or append to an open one, and keep stepping
			prog.delete();
			for (int i = 0; i < $urandom_range(1, 4); i++)
				prog.push_back(pick_op());
			load_prog(1'b0, 1'b0);
			run_steps($urandom_range(1, 8), 75, -1);
		end
	endtask

	initial begin
		int phase_start;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A step with nothing loaded halts.
		run_steps(1, 0, -1);
		// Wrap the pointer both ways, wrap a cell down, output, then input
		// missing and present.
		prog = '{CH_LEFT, CH_RIGHT, CH_DEC, CH_OUT, CH_IN, CH_INC};
		load_prog(1'b1, 1'b0);
		run_steps(4, 100, -1);
		run_steps(1, 0, -1);
		run_steps(1, 100, 8'hFE);
		run_steps(1, 100, -1);
		// Run a loop once, skip it on zero, hit a lone close, then sit stopped.
		prog = '{CH_IN, CH_OPEN, CH_DEC, CH_CLOSE, CH_CLOSE};
		load_prog(1'b1, 1'b0);
		run_steps(9, 100, 1);

		// Long programs for the limits: loop stack full, skip nesting too
		// deep, end of program inside a skip.
		build_run(CH_OPEN, LOOP_DEPTH + 2);
		load_prog(1'b1, 1'b0);
		run_steps(LOOP_DEPTH + 4, 100, 8'h5A);
		build_run(CH_OPEN, 130);
		load_prog(1'b1, 1'b0);
		run_steps(135, 100, 0);
		build_run(CH_OPEN, 1);
		load_prog(1'b1, 1'b0);
		run_steps(4, 100, 0);
		drain_results();

		// Random part in four idling phases; pause for a full drain between them.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 55;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 55;
				end
				default: begin
					send_idle_pct = 34;
					recv_stall_pct = 34;
				end
			endcase
			// Block the receiver for a long stretch while steps keep coming,
			// so the block backs up and stalls its input.
			if (ph == 0)
				hold_requests <= hold_requests + 1;
			phase_start = tracker.loads + tracker.steps;
			while (tracker.loads + tracker.steps - phase_start < PHASE_BEATS)
				random_program();
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d load beats and %0d step beats; checked %0d results.",
		         tracker.loads, tracker.steps, tracker.checked);
		$display("Results by status: exec %0d, out %0d, need %0d, halt %0d, over %0d, unmatched %0d",
		         tracker.status_seen[ST_EXEC], tracker.status_seen[ST_OUT],
		         tracker.status_seen[ST_NEED], tracker.status_seen[ST_HALT],
		         tracker.status_seen[ST_OVER], tracker.status_seen[ST_UNMATCHED]);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("ERROR: %0d mismatches, %0d results missing",
			         tracker.mismatches, tracker.pending());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
